FILE: rtl/core/shash_pkg.sv
package shash_pkg;

	// Item kinds carried on the input tuser bit.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEEP_CASE  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_POLYNOMIAL = 1'b1;
	localparam int unsigned CFG_DATA_W = 32;

	// Reset values of the configuration registers.
	localparam logic        KEEP_CASE_RESET  = 1'b1;
	localparam logic [31:0] POLYNOMIAL_RESET = 32'h82F63B78;

	// Stream widths: length in the low 32 bits, data byte above, padded to bytes.
	localparam int unsigned LENGTH_W  = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CRC_W     = 32;
	localparam int unsigned IN_DATA_W = ((LENGTH_W + BYTE_W + 7) / 8) * 8;

	// ASCII letters for case folding.
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef struct packed {
		logic                keep_case;
		logic [CRC_W-1:0]    polynomial;
	} cfg_t;

	// One request as it moves down the pre-hash stages.
	typedef struct packed {
		logic                cmd;
		logic [LENGTH_W-1:0] length;
		logic [BYTE_W-1:0]   data_byte;
		logic [CRC_W-1:0]    crc;
	} item_t;

	typedef struct packed {
		logic             valid;
		logic [CRC_W-1:0] hash;
	} res_t;

	// Fold one byte into a reflected CRC register, one bit per step.
	function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b, input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int i = 0; i < BYTE_W; i++) begin
			c = (c >> 1) ^ (poly & {CRC_W{c[0]}});
		end
		return c;
	endfunction

	// Map A..Z to a..z, leave every other byte alone.
	function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		r = b;
		if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/shash_cfg.sv
module shash_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [shash_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [shash_pkg::CFG_DATA_W-1:0]    cfg_data,
	output shash_pkg::cfg_t                     cfg
);
	import shash_pkg::*;

	logic             keep_case_q;
	logic [CRC_W-1:0] polynomial_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_case_q  <= KEEP_CASE_RESET;
			polynomial_q <= POLYNOMIAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEEP_CASE:  keep_case_q  <= cfg_data[0];
				REG_POLYNOMIAL: polynomial_q <= cfg_data[CRC_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.keep_case  = keep_case_q;
	assign cfg.polynomial = polynomial_q;

endmodule

FILE: rtl/core/shash_pre.sv
module shash_pre (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  logic                               in_cmd,
	input  logic [shash_pkg::IN_DATA_W-1:0]    in_data,
	input  shash_pkg::cfg_t                    cfg,
	output logic                               out_valid,
	output shash_pkg::item_t                   out_item
);
	import shash_pkg::*;

	logic  vld_s1, vld_s2, vld_s3, vld_s4;
	item_t item_s1, item_s2, item_s3, item_s4;
	item_t nxt_s2, nxt_s3, nxt_s4;

	// Each stage folds one length byte into the partial CRC, which starts at zero.
	// The data byte is case folded in the first stage when keep_case is clear.
	always_comb begin
		nxt_s2 = item_s1;
		nxt_s2.crc = fold_byte('0, item_s1.length[7:0], cfg.polynomial);
		if (!cfg.keep_case) begin
			nxt_s2.data_byte = to_lower(item_s1.data_byte);
		end
		nxt_s3 = item_s2;
		nxt_s3.crc = fold_byte(item_s2.crc, item_s2.length[15:8], cfg.polynomial);
		nxt_s4 = item_s3;
		nxt_s4.crc = fold_byte(item_s3.crc, item_s3.length[23:16], cfg.polynomial);
	end

	// Valid bits of the stages; the whole line moves together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Payload of the stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1.cmd       <= in_cmd;
			item_s1.length    <= in_data[LENGTH_W-1:0];
			item_s1.data_byte <= in_data[LENGTH_W +: BYTE_W];
			item_s1.crc       <= '0;
			item_s2           <= nxt_s2;
			item_s3           <= nxt_s3;
			item_s4           <= nxt_s4;
		end
	end

	assign out_valid = vld_s4;
	assign out_item  = item_s4;

endmodule

FILE: rtl/core/shash_core.sv
module shash_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  shash_pkg::item_t      in_item,
	input  shash_pkg::cfg_t       cfg,
	output shash_pkg::res_t       res
);
	import shash_pkg::*;

	logic [CRC_W-1:0]    crc_q, crc_n;
	logic [LENGTH_W-1:0] rem_q, rem_n;
	logic                upd;
	logic                emit;

	// Start: finish the length salt. Byte: fold into the running CRC if a
	// string is open, and count it off.
	always_comb begin
		crc_n = crc_q;
		rem_n = rem_q;
		upd   = 1'b0;
		emit  = 1'b0;
		if (in_valid) begin
			if (in_item.cmd == CMD_START) begin
				crc_n = fold_byte(in_item.crc, in_item.length[31:24], cfg.polynomial);
				rem_n = in_item.length;
				upd   = 1'b1;
				emit  = (in_item.length == '0);
			end else if (rem_q != '0) begin
				crc_n = fold_byte(crc_q, in_item.data_byte, cfg.polynomial);
				rem_n = rem_q - LENGTH_W'(1);
				upd   = 1'b1;
				emit  = (rem_n == '0);
			end
		end
	end

	// Running CRC and the count of bytes still expected.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			rem_q <= '0;
		end else if (adv && upd) begin
			crc_q <= crc_n;
			rem_q <= rem_n;
		end
	end

	assign res.valid = emit;
	assign res.hash  = crc_n;

endmodule

FILE: rtl/core/shash_out.sv
module shash_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  shash_pkg::res_t               res,
	output logic                          adv,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [shash_pkg::CRC_W-1:0]   m_axis_tdata
);
	import shash_pkg::*;

	logic             out_valid_q;
	logic [CRC_W-1:0] hash_q;

	// The line stalls only when a hash is due and the result register stays full.
	assign adv = !res.valid || !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && adv) begin
			hash_q <= res.hash;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = hash_q;

endmodule

FILE: rtl/core/salted_crc32_string_hash.sv
// Channel   Direction  Payload
// s_axis    in         tdata: length[31:0], data_byte[39:32]; tuser: command
// m_axis    out        tdata: hash[31:0]
// cfg       in         index 0 keep_case, index 1 polynomial
//
// One request is taken per cycle unless the line stalls; the hash of a string
// is registered when the request that completes it leaves the pre-hash stages.
// Three pre-hash stages fold the first three length bytes, one byte per stage;
// the last stage folds one byte into the running CRC, which sets the clock.
// The line stalls only while a hash is due and the result register is full.
// Reset clears the CRC, the byte count, all valid bits and restores the registers.
module salted_crc32_string_hash (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [shash_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [shash_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [shash_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // length, data_byte
	input  logic                                s_axis_tuser,  // command
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [shash_pkg::CRC_W-1:0]         m_axis_tdata   // hash
);
	import shash_pkg::*;

	cfg_t  cfg;
	item_t item;
	logic  item_valid;
	res_t  res;
	logic  adv;

	shash_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	shash_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cfg       (cfg),
		.out_valid (item_valid),
		.out_item  (item)
	);

	shash_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (item_valid),
		.in_item  (item),
		.cfg      (cfg),
		.res      (res)
	);

	shash_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	assign s_axis_tready = adv;

endmodule

FILE: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import shash_pkg::*;

	localparam int DRAIN_CYCLES   = 12;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	// One request as the sender sees it.
	typedef struct packed {
		logic                cmd;
		logic [LENGTH_W-1:0] length;
		logic [BYTE_W-1:0]   data_byte;
	} str_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;  // length, data_byte
	logic                 s_axis_tuser = 1'b0;  // command
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [CRC_W-1:0]     m_axis_tdata;  // hash

	// Requests waiting to be sent and hashes waiting to come back.
	str_req_t         req_pending[$];
	logic [CRC_W-1:0] hash_expected[$];

	// Shadow of the hash state and the configuration.
	logic             model_case_sens = KEEP_CASE_RESET;
	logic [CRC_W-1:0] model_poly = POLYNOMIAL_RESET;
	logic [CRC_W-1:0] model_crc = '0;
	logic [31:0]      model_left = '0;

	int send_gap = 0;
	int recv_gap = 0;
	int hold_asked = 0;
	int hold_served = 0;
	bit no_idle = 1'b0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	logic [CRC_W-1:0] hash_want;

	salted_crc32_string_hash u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Reflected CRC update by one byte, LSB first.
	function automatic logic [CRC_W-1:0] mix_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b, input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] c;
		c = crc ^ CRC_W'(b);
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
		if (b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'h20;
		end
		return b;
	endfunction

	// Advance the shadow state by one accepted request and queue any hash it completes.
	task automatic predict_hash(input str_req_t r);
		logic [BYTE_W-1:0] b;
		logic [CRC_W-1:0]  c;
		if (r.cmd == CMD_START) begin
			c = '0;
			for (int k = 0; k < 4; k++) begin
				c = mix_byte(c, r.length[8*k +: 8], model_poly);
			end
			model_crc = c;
			model_left = r.length;
			if (r.length == 0) begin
				hash_expected.push_back(c);
			end
		end else if (model_left != 0) begin
			b = r.data_byte;
			if (!model_case_sens) begin
				b = fold_case(b);
			end
			model_crc = mix_byte(model_crc, b, model_poly);
			model_left--;
			if (model_left == 0) begin
				hash_expected.push_back(model_crc);
			end
		end
	endtask

	task automatic queue_req(input logic cmd, input logic [31:0] len, input logic [7:0] b);
		str_req_t r;
		r.cmd = cmd;
		r.length = len;
		r.data_byte = b;
		req_pending.push_back(r);
	endtask

	// Letters are favored so that case folding is exercised often.
	function automatic logic [7:0] pick_byte();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 20) begin
			return 8'($urandom_range(8'h41, 8'h5A));
		end else if (sel < 35) begin
			return 8'($urandom_range(8'h61, 8'h7A));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int pick_length();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			return $urandom_range(0, 3);
		end else if (sel < 90) begin
			return $urandom_range(4, 16);
		end
		return $urandom_range(17, 64);
	endfunction

	// A start request announcing len bytes, followed by sent data bytes.
	task automatic queue_string(input logic [31:0] len, input int sent);
		queue_req(CMD_START, len, 8'($urandom_range(0, 255)));
		repeat (sent) begin
			queue_req(CMD_BYTE, $urandom(), pick_byte());
		end
	endtask

	// Mostly complete strings, some abandoned ones and some stray bytes.
	task automatic queue_mix(input int n);
		int made;
		int sel;
		int len;
		int cut;
		logic [31:0] lenw;
		made = 0;
		@(negedge clk);
		while (made < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 76) begin
				len = pick_length();
				queue_string(len, len);
				made += len + 1;
			end else if (sel < 90) begin
				lenw = $urandom_range(0, 1) ? ($urandom() | 32'h10) : $urandom_range(8, 14);
				cut = $urandom_range(0, 6);
				queue_string(lenw, cut);
				made += cut + 1;
			end else begin
				repeat ($urandom_range(1, 3)) begin
					queue_req(CMD_BYTE, $urandom(), pick_byte());
				end
			end
		end
	endtask

	// Wait until every request is sent, every hash is back and the pipeline is empty.
	task automatic wait_drained();
		while (req_pending.size() != 0 || s_axis_tvalid || hash_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_KEEP_CASE) begin
			model_case_sens = val[0];
		end else begin
			model_poly = val;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic case_sens, input logic [31:0] poly, input int n);
		wait_drained();
		write_reg(REG_KEEP_CASE, {31'd0, case_sens});
		write_reg(REG_POLYNOMIAL, poly);
		queue_mix(n);
	endtask

	// Sender: offers the oldest pending request, with random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_hash(req_pending.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (req_pending.size() != 0 && !no_idle
						&& $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 12);
					s_axis_tvalid <= 1'b0;
				end else if (req_pending.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {req_pending[0].data_byte, req_pending[0].length};
					s_axis_tuser <= req_pending[0].cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each hash against the oldest expected one and stalls at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (hash_expected.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("unexpected hash %h at %0t", m_axis_tdata, $realtime);
					end
					mismatch_count++;
				end else begin
					hash_want = hash_expected.pop_front();
					if (m_axis_tdata !== hash_want) begin
						if (mismatch_count < 10) begin
							$display("hash mismatch at %0t: expected %h, got %h",
								$realtime, hash_want, m_axis_tdata);
						end
						mismatch_count++;
					end
				end
			end
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				recv_gap = LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(0, 12);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Count cycles in which neither side moves anything.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a byte with no string open is ignored.
		queue_req(CMD_BYTE, $urandom(), 8'hFF);
		// Zero length hashes the length bytes alone.
		queue_req(CMD_START, 32'd0, 8'h00);
		queue_string(32'd3, 0);
		queue_req(CMD_BYTE, $urandom(), 8'h41);
		queue_req(CMD_BYTE, $urandom(), 8'h7A);
		queue_req(CMD_BYTE, $urandom(), 8'h00);
		// Largest length, then abandoned by a new start.
		queue_req(CMD_START, 32'hFFFF_FFFF, 8'hFF);
		queue_req(CMD_BYTE, 32'hFFFF_FFFF, 8'hFF);
		queue_req(CMD_START, 32'd2, 8'h00);
		queue_req(CMD_BYTE, 32'd0, 8'h51);
		queue_req(CMD_BYTE, $urandom(), 8'h80);
		// Case folding switched on in the middle of an open string.
		queue_req(CMD_START, 32'd2, 8'h5A);
		queue_req(CMD_BYTE, $urandom(), 8'h4D);
		wait_drained();
		write_reg(REG_KEEP_CASE, 32'd0);
		@(negedge clk);
		queue_req(CMD_BYTE, $urandom(), 8'h5A);
		// Letters at and just outside the A..Z bounds.
		queue_req(CMD_START, 32'd5, 8'h41);
		queue_req(CMD_BYTE, $urandom(), 8'h40);
		queue_req(CMD_BYTE, $urandom(), 8'h41);
		queue_req(CMD_BYTE, $urandom(), 8'h5A);
		queue_req(CMD_BYTE, $urandom(), 8'h5B);
		queue_req(CMD_BYTE, $urandom(), 8'h61);
		queue_req(CMD_BYTE, $urandom(), 8'h00);

		run_phase(1'b1, POLYNOMIAL_RESET, 350);

		// Receiver holds off while zero-length strings pile up behind it.
		wait_drained();
		hold_asked++;
		@(negedge clk);
		repeat (40) begin
			queue_req(CMD_START, 32'd0, 8'($urandom_range(0, 255)));
		end
		queue_mix(30);

		run_phase(1'b0, 32'hEDB8_8320, 350);
		run_phase(1'b0, 32'hFFFF_FFFF, 250);
		run_phase(1'b1, 32'h0000_0000, 250);
		run_phase(1'($urandom_range(0, 1)), $urandom(), 250);

		// Closing stretch at full rate on both sides.
		wait_drained();
		no_idle = 1'b1;
		run_phase(1'b1, POLYNOMIAL_RESET, 250);

		wait_drained();
		if (mismatch_count == 0 && hash_expected.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
